// ----- hdl/phase_vocoder_bin_frequency_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bin frequency block
// Concurrent checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PHASE_VOCODER_BIN_FREQUENCY_MACROS_SVH
`define PHASE_VOCODER_BIN_FREQUENCY_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define PVBF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// antecedent in this cycle, consequent in the next
`define PVBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define PVBF_ASSERT(label, clk, rst, prop, msg)
`define PVBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/pvbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbf_pkg
// Types, widths and register codes shared by the bin frequency block.
// ----------------------------------------------------------------------------
package pvbf_pkg;

   // field widths
   localparam int BIN_WIDTH      = 12;
   localparam int PHASE_WIDTH    = 16;
   localparam int OVS_WIDTH      = 7;
   localparam int FPB_WIDTH      = 24;
   localparam int FREQ_WIDTH     = 32;

   // default transform size
   localparam int FFT_SIZE_DEFAULT = 4096;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OVERSAMPLING = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FREQ_PER_BIN = 2'd2;

   localparam logic [OVS_WIDTH-1:0]   OVS_RESET   = 7'd4;
   localparam logic [PHASE_WIDTH-1:0] STEP_RESET  = 16'd16384;
   localparam logic [FPB_WIDTH-1:0]   FPB_RESET   = 24'd12000;

   // queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;

   // datapath widths of the back end
   localparam int OVSDEV_WIDTH = OVS_WIDTH + 1 + PHASE_WIDTH;          // 24
   localparam int NUM_WIDTH    = BIN_WIDTH + PHASE_WIDTH + 2;          // 30
   localparam int FPB_SPLIT    = FPB_WIDTH / 2;                        // 12
   localparam int PART_WIDTH   = NUM_WIDTH + FPB_SPLIT + 1;            // 43
   localparam int SUM_WIDTH    = NUM_WIDTH + FPB_WIDTH;                // 54
   localparam int QUOT_WIDTH   = SUM_WIDTH - PHASE_WIDTH;              // 38

   localparam logic signed [SUM_WIDTH-1:0]  ROUND_HALF = 54'sd32768;
   localparam logic signed [FREQ_WIDTH-1:0] SAT_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [FREQ_WIDTH-1:0] SAT_MIN    = 32'sh8000_0000;

   typedef struct packed {
      logic [BIN_WIDTH-1:0]   bin_index;
      logic [PHASE_WIDTH-1:0] phase;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_WIDTH-1:0]         bin_out;
      logic signed [FREQ_WIDTH-1:0] true_freq;
   } rsp_payload_type;

   typedef struct packed {
      logic [OVS_WIDTH-1:0]   oversampling;
      logic [PHASE_WIDTH-1:0] phase_step_per_bin;
      logic [FPB_WIDTH-1:0]   freq_per_bin;
   } cfg_type;

   // one classified transaction: bin and wrapped phase deviation
   typedef struct packed {
      logic [BIN_WIDTH-1:0]          bin;
      logic signed [PHASE_WIDTH-1:0] dev;
   } queue_entry_type;

endpackage

// ----- hdl/phase_vocoder_bin_frequency.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_vocoder_bin_frequency
// Phase-vocoder analysis: true frequency of each FFT bin from its phase.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns one result per transaction, in
// order; while neither a low rsp_ready nor the clearing pass holds the flow, the
// sustained rate is one per cycle, set by the phase store, which has one read
// port and one write port (one read at accept, one write as the transaction
// leaves the lookup stage, with forwarding when a bin repeats). A request
// passes through one lookup stage, the front-to-back queue, three math stages
// and the output register before its result reaches rsp_valid. After reset
// the phase store's FFT_SIZE/2+1 entries (2049 at the default size) are swept
// to zero with req_ready low; configuration writes are taken throughout.
// Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module phase_vocoder_bin_frequency #(
   parameter int FFT_SIZE = pvbf_pkg::FFT_SIZE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pvbf_pkg::req_payload_type              req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pvbf_pkg::rsp_payload_type              rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pvbf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pvbf_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import pvbf_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_data;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_data;

   // configuration registers, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OVERSAMPLING: cfg_in.oversampling       = csr_data[OVS_WIDTH-1:0];
            CSR_PHASE_STEP:   cfg_in.phase_step_per_bin = csr_data[PHASE_WIDTH-1:0];
            CSR_FREQ_PER_BIN: cfg_in.freq_per_bin       = csr_data[FPB_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oversampling       <= OVS_RESET;
         cfg_ff.phase_step_per_bin <= STEP_RESET;
         cfg_ff.freq_per_bin       <= FPB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pvbf_front #(
      .FFT_SIZE (FFT_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pvbf_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pvbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/pvbf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2049
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/pvbf_front.sv -----
`timescale 1ns / 1ps
`include "phase_vocoder_bin_frequency_macros.svh"
// ----------------------------------------------------------------------------
// pvbf_front
// Accepts transactions, looks up the previous phase of the bin and forms the
// wrapped phase deviation; owns the phase store and its clearing pass.
// ----------------------------------------------------------------------------
module pvbf_front #(
   parameter int FFT_SIZE = pvbf_pkg::FFT_SIZE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pvbf_pkg::req_payload_type req_data,
   input  pvbf_pkg::cfg_type         cfg,
   output logic                      push_valid,
   input  logic                      push_ready,
   output pvbf_pkg::queue_entry_type push_data
);
   import pvbf_pkg::*;

   localparam int BIN_COUNT  = FFT_SIZE / 2 + 1;
   localparam int ADDR_WIDTH = $clog2(BIN_COUNT);
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(BIN_COUNT - 1);

   // clearing pass state
   logic                   clr_active_ff, clr_active_in;
   logic [ADDR_WIDTH-1:0]  clr_addr_ff, clr_addr_in;

   // lookup stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [BIN_WIDTH-1:0]   s1_bin_ff, s1_bin_in;
   logic [PHASE_WIDTH-1:0] s1_phase_ff, s1_phase_in;
   logic                   s1_inrange_ff, s1_inrange_in;
   logic [PHASE_WIDTH-1:0] s1_prod_ff, s1_prod_in;
   logic                   s1_fwd_ff, s1_fwd_in;
   logic [PHASE_WIDTH-1:0] s1_fwd_phase_ff, s1_fwd_phase_in;

   logic                   req_fire;
   logic                   s1_move;
   logic                   req_inrange;
   logic                   fwd_hit;
   logic                   ram_we;
   logic [ADDR_WIDTH-1:0]  ram_waddr;
   logic [PHASE_WIDTH-1:0] ram_wdata;
   logic [PHASE_WIDTH-1:0] ram_rdata;
   logic [PHASE_WIDTH-1:0] prev_phase;
   logic [PHASE_WIDTH-1:0] diff;

   // handshake: no clearing pass runs, and the stage is free or drains into the queue this cycle
   assign s1_move   = s1_valid_ff && push_ready;
   assign req_ready = !clr_active_ff && (!s1_valid_ff || push_ready);
   assign req_fire  = req_valid && req_ready;

   assign req_inrange = 32'(req_data.bin_index) < 32'(BIN_COUNT);
   // the stage ahead writes this bin at the same edge: take its phase
   assign fwd_hit = s1_valid_ff && s1_inrange_ff && (s1_bin_ff == req_data.bin_index);

   // clearing pass after reset, one entry per cycle
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   // lookup stage next values
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_bin_in       = s1_bin_ff;
      s1_phase_in     = s1_phase_ff;
      s1_inrange_in   = s1_inrange_ff;
      s1_prod_in      = s1_prod_ff;
      s1_fwd_in       = s1_fwd_ff;
      s1_fwd_phase_in = s1_fwd_phase_ff;
      if (req_fire) begin
         s1_valid_in     = 1'b1;
         s1_bin_in       = req_data.bin_index;
         s1_phase_in     = req_data.phase;
         s1_inrange_in   = req_inrange;
         // only the low 16 bits of bin * step matter after the wrap
         s1_prod_in      = PHASE_WIDTH'(req_data.bin_index * cfg.phase_step_per_bin);
         s1_fwd_in       = fwd_hit;
         s1_fwd_phase_in = s1_phase_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff       <= s1_bin_in;
      s1_phase_ff     <= s1_phase_in;
      s1_inrange_ff   <= s1_inrange_in;
      s1_prod_ff      <= s1_prod_in;
      s1_fwd_ff       <= s1_fwd_in;
      s1_fwd_phase_ff <= s1_fwd_phase_in;
   end

   // phase store write: zeros during the clearing pass, else the new phase
   assign ram_we    = clr_active_ff || (s1_move && s1_inrange_ff);
   assign ram_waddr = clr_active_ff ? clr_addr_ff : ADDR_WIDTH'(s1_bin_ff);
   assign ram_wdata = clr_active_ff ? '0 : s1_phase_ff;

   pvbf_ram #(
      .WIDTH (PHASE_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_phase_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_fire),
      .raddr (ADDR_WIDTH'(req_data.bin_index)),
      .rdata (ram_rdata)
   );

   // out-of-range bins see a stored phase of zero
   always_comb begin
      if (!s1_inrange_ff) begin
         prev_phase = '0;
      end else if (s1_fwd_ff) begin
         prev_phase = s1_fwd_phase_ff;
      end else begin
         prev_phase = ram_rdata;
      end
   end

   // two's complement wrap to a signed half turn
   assign diff = s1_phase_ff - prev_phase - s1_prod_ff;

   assign push_valid    = s1_valid_ff;
   assign push_data.bin = s1_bin_ff;
   assign push_data.dev = $signed(diff);

   `PVBF_ASSERT(a_clear_excludes_work, clock, reset, clr_active_ff |-> !s1_valid_ff, "transaction in flight during clearing pass")
   `PVBF_ASSERT(a_accept_needs_room, clock, reset, (req_fire && s1_valid_ff) |-> push_ready, "accepted over a stalled lookup stage")

endmodule

// ----- hdl/pvbf_fifo.sv -----
`timescale 1ns / 1ps
`include "phase_vocoder_bin_frequency_macros.svh"
// ----------------------------------------------------------------------------
// pvbf_fifo
// Short register queue that decouples the front lookup from the back math.
// ----------------------------------------------------------------------------
module pvbf_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  pvbf_pkg::queue_entry_type push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output pvbf_pkg::queue_entry_type pop_data
);
   import pvbf_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(QUEUE_DEPTH);

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointers wrap on their own width
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PVBF_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "queue count beyond depth")

endmodule

// ----- hdl/pvbf_back.sv -----
`timescale 1ns / 1ps
`include "phase_vocoder_bin_frequency_macros.svh"
// ----------------------------------------------------------------------------
// pvbf_back
// Turns the wrapped deviation into a true frequency: bin offset, split
// multiply by Hz per bin, rounding and saturation, then the output register.
// ----------------------------------------------------------------------------
module pvbf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  pvbf_pkg::queue_entry_type pop_data,
   input  pvbf_pkg::cfg_type         cfg,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pvbf_pkg::rsp_payload_type rsp_data
);
   import pvbf_pkg::*;

   logic                          advance;

   // stage 1: bins scaled by 2^16
   logic                          b1_valid_ff, b1_valid_in;
   logic [BIN_WIDTH-1:0]          b1_bin_ff, b1_bin_in;
   logic signed [NUM_WIDTH-1:0]   b1_num_ff, b1_num_in;
   logic signed [OVSDEV_WIDTH-1:0] ovs_dev;

   // stage 2: partial products against low and high halves of Hz per bin
   logic                          b2_valid_ff, b2_valid_in;
   logic [BIN_WIDTH-1:0]          b2_bin_ff, b2_bin_in;
   logic signed [PART_WIDTH-1:0]  b2_lo_ff, b2_lo_in;
   logic signed [PART_WIDTH-1:0]  b2_hi_ff, b2_hi_in;

   // stage 3: rounded quotient
   logic                          b3_valid_ff, b3_valid_in;
   logic [BIN_WIDTH-1:0]          b3_bin_ff, b3_bin_in;
   logic signed [QUOT_WIDTH-1:0]  b3_quot_ff, b3_quot_in;
   logic signed [SUM_WIDTH-1:0]   sum;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type               rsp_data_ff, rsp_data_in;
   logic [QUOT_WIDTH-FREQ_WIDTH:0] quot_top;

   // whole pipeline steps when the output register can take a transaction
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   // stage 1 math
   assign ovs_dev   = $signed({1'b0, cfg.oversampling}) * pop_data.dev;

   // stage 3 math: floor((hi * 2^12 + lo + 2^15) / 2^16)
   assign sum = (SUM_WIDTH'(b2_hi_ff) <<< FPB_SPLIT) + SUM_WIDTH'(b2_lo_ff) + ROUND_HALF;

   // saturation on the top bits of the quotient
   assign quot_top = b3_quot_ff[QUOT_WIDTH-1:FREQ_WIDTH-1];

   always_comb begin
      b1_valid_in  = b1_valid_ff;
      b1_bin_in    = b1_bin_ff;
      b1_num_in    = b1_num_ff;
      b2_valid_in  = b2_valid_ff;
      b2_bin_in    = b2_bin_ff;
      b2_lo_in     = b2_lo_ff;
      b2_hi_in     = b2_hi_ff;
      b3_valid_in  = b3_valid_ff;
      b3_bin_in    = b3_bin_ff;
      b3_quot_in   = b3_quot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         b1_valid_in = pop_valid;
         b1_bin_in   = pop_data.bin;
         b1_num_in   = $signed({2'b00, pop_data.bin, {PHASE_WIDTH{1'b0}}})
                       + NUM_WIDTH'(ovs_dev);

         b2_valid_in = b1_valid_ff;
         b2_bin_in   = b1_bin_ff;
         b2_lo_in    = b1_num_ff * $signed({1'b0, cfg.freq_per_bin[FPB_SPLIT-1:0]});
         b2_hi_in    = b1_num_ff * $signed({1'b0, cfg.freq_per_bin[FPB_WIDTH-1:FPB_SPLIT]});

         b3_valid_in = b2_valid_ff;
         b3_bin_in   = b2_bin_ff;
         b3_quot_in  = sum[SUM_WIDTH-1:PHASE_WIDTH];

         rsp_valid_in        = b3_valid_ff;
         rsp_data_in.bin_out = b3_bin_ff;
         if (quot_top == '0 || quot_top == '1) begin
            rsp_data_in.true_freq = b3_quot_ff[FREQ_WIDTH-1:0];
         end else if (b3_quot_ff[QUOT_WIDTH-1]) begin
            rsp_data_in.true_freq = SAT_MIN;
         end else begin
            rsp_data_in.true_freq = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         b3_valid_ff  <= b3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_bin_ff   <= b1_bin_in;
      b1_num_ff   <= b1_num_in;
      b2_bin_ff   <= b2_bin_in;
      b2_lo_ff    <= b2_lo_in;
      b2_hi_ff    <= b2_hi_in;
      b3_bin_ff   <= b3_bin_in;
      b3_quot_ff  <= b3_quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PVBF_ASSERT_NEXT(a_stall_freezes_stages, clock, reset, !advance, $stable({b1_valid_ff, b2_valid_ff, b3_valid_ff}), "pipeline moved while output stalled")

endmodule
